FILE: rtl/sida_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the controller state type and the cell control bundle.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

    // Width of one BCD digit cell
    localparam int BCD_W = 4;

    // ASCII codes
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Control shared by every cell of the digit chain
    typedef struct packed {
        logic clear;    // zero all digits
        logic dabble;   // add-3 adjust, then shift one bit in from below
        logic shift;    // move whole digits one place toward the top
    } t_cell_ctrl;

endpackage

FILE: rtl/sida_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on sida_pkg for the digit width and the control bundle.
`timescale 1ns / 1ps

module sida_cell (
    input  logic                         i_clk,
    input  sida_pkg::t_cell_ctrl         i_ctrl,
    input  logic                         i_carry,
    input  logic [sida_pkg::BCD_W-1:0]   i_digit,
    output logic                         o_carry,
    output logic [sida_pkg::BCD_W-1:0]   o_digit
);

    logic [sida_pkg::BCD_W-1:0] r_digit;
    logic [sida_pkg::BCD_W-1:0] adj;

    // Add 3 when the digit would reach 10 or more after the shift
    always_comb begin
        adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    assign o_carry = adj[sida_pkg::BCD_W-1];
    assign o_digit = r_digit;

    // Digit register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.dabble) begin
            r_digit <= {adj[sida_pkg::BCD_W-2:0], i_carry};
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit;
        end
    end

endmodule

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sida_pkg and sida_cell (a chain of BCD digit cells).
`timescale 1ns / 1ps
//
// Usage:
//   Drive i_value and raise start while busy is low; the item is taken at
//   that clock edge and busy rises on the next cycle.
//   The text comes out one character per strobe on o_valid, most significant
//   first: '-' for a negative value, then the digits with leading zeros
//   dropped. o_last_char marks the final character. Zero gives a single '0'.
//   Each character is present for exactly one cycle; the receiver must take
//   it then, there is no back-pressure.
// Timing:
//   The minus sign appears in the cycle after the accept edge. The magnitude is
//   then shifted through the digit chain one bit per cycle, after which the
//   chain shifts one digit per cycle toward the output, emitting each
//   significant digit.
//   The block takes no new item until the last digit position has been
//   emitted and busy has fallen; the bit-serial conversion through the
//   cell chain sets how long one item occupies it.
// Reset:
//   i_rst_n low (synchronous) returns the controller to idle; any item in
//   progress is dropped and no further characters are emitted.

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         busy,
    output logic                         o_valid,
    output logic [6:0]                   o_char_code,
    output logic                         o_last_char
);

    // Digits needed for a magnitude of up to 2^(VALUE_BITS-1)
    localparam int NUM_DIGITS = (VALUE_BITS * 3) / 10 + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DCNT_W     = $clog2(NUM_DIGITS);

    sida_pkg::t_state r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic                  r_lead, n_lead;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DCNT_W-1:0]     r_dcnt, n_dcnt;

    sida_pkg::t_cell_ctrl            cell_ctrl;
    logic [NUM_DIGITS:0]             carry;
    logic [sida_pkg::BCD_W-1:0]      dig [NUM_DIGITS];
    logic [sida_pkg::BCD_W-1:0]      top_digit;
    logic                            last_pos;
    logic                            emit_digit;

    // Digit chain: bit carries and whole digits both move upward
    assign carry[0] = r_mag[VALUE_BITS-1];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic [sida_pkg::BCD_W-1:0] below;
        if (g == 0) begin : g_first
            assign below = '0;
        end else begin : g_rest
            assign below = dig[g-1];
        end
        sida_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_carry (carry[g]),
            .i_digit (below),
            .o_carry (carry[g+1]),
            .o_digit (dig[g])
        );
    end

    assign top_digit  = dig[NUM_DIGITS-1];
    assign last_pos   = (r_dcnt == DCNT_W'(NUM_DIGITS - 1));
    assign emit_digit = (r_state == sida_pkg::ST_EMIT)
                        && (last_pos || !r_lead || (top_digit != '0));

    // Next state and datapath registers
    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_lead  = r_lead;
        n_cnt   = r_cnt;
        n_dcnt  = r_dcnt;
        case (r_state)
            sida_pkg::ST_IDLE: begin
                if (start) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt   = '0;
                    n_state = sida_pkg::ST_CONV;
                end
            end
            sida_pkg::ST_CONV: begin
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    n_dcnt  = '0;
                    n_lead  = 1'b1;
                    n_state = sida_pkg::ST_EMIT;
                end
            end
            sida_pkg::ST_EMIT: begin
                n_dcnt = r_dcnt + 1'b1;
                if (emit_digit) begin
                    n_lead = 1'b0;
                end
                if (last_pos) begin
                    n_state = sida_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sida_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and cell control
    always_comb begin
        cell_ctrl   = '0;
        o_valid     = 1'b0;
        o_char_code = sida_pkg::CHAR_ZERO;
        o_last_char = 1'b0;
        case (r_state)
            sida_pkg::ST_IDLE: begin
                cell_ctrl.clear = 1'b1;
            end
            sida_pkg::ST_CONV: begin
                cell_ctrl.dabble = 1'b1;
                if (r_neg && (r_cnt == '0)) begin
                    o_valid     = 1'b1;
                    o_char_code = sida_pkg::CHAR_MINUS;
                end
            end
            sida_pkg::ST_EMIT: begin
                cell_ctrl.shift = 1'b1;
                o_valid         = emit_digit;
                o_char_code     = sida_pkg::CHAR_ZERO + 7'(top_digit);
                o_last_char     = emit_digit && last_pos;
            end
            default: begin
                cell_ctrl = '0;
            end
        endcase
    end

    assign busy = (r_state != sida_pkg::ST_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sida_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_lead  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dcnt  <= n_dcnt;
            r_lead  <= n_lead;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
    end

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |=> !busy)
        else $error("block still busy after the last character");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid)
        else $error("character strobe while idle");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == sida_pkg::CHAR_MINUS))
            |-> (r_state == sida_pkg::ST_CONV) && !o_last_char)
        else $error("minus sign outside the first conversion cycle");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sida_pkg::ST_EMIT) |-> (top_digit <= 4'd9))
        else $error("digit chain holds a non-decimal digit");

endmodule
